### design/buddy_memory_allocator_defines.svh
// Assertion macros shared by the checker of the buddy allocator.
`ifndef BUDDY_MEMORY_ALLOCATOR_DEFINES_SVH
`define BUDDY_MEMORY_ALLOCATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BMA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bma_pkg.sv
// Types, constants and helper functions of the buddy allocator.
package bma_pkg;

  localparam int MAX_ORDER_DEF = 10;
  localparam int SHIFT_W       = 5;
  localparam int SHIFT_RST     = 4;
  localparam int SHIFT_MAX     = 16;
  localparam int ADDR_W        = 26;
  localparam int BYTES_W       = 27;
  localparam int ORD_W         = 5;
  localparam int AM_W          = 5;
  localparam int FM_WORD_W     = 32;
  localparam int FM_BIT_W      = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_FREE  = 2'd2,
    ST_BAD_ADDR = 2'd3
  } bma_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_PICK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPLIT_RD,
    S_SPLIT_WR,
    S_MARK,
    S_FCHK,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_INS_RD,
    S_INS_WR,
    S_RESP
  } bma_state_t;

  typedef struct packed {
    logic        clr;
    logic        load;
    logic        decode;
    logic        pick;
    logic        scan_next;
    logic        take;
    logic        split_rd;
    logic        split_wr;
    logic        mark;
    logic        fstart;
    logic        merge_rd;
    logic        merge_take;
    logic        ins_rd;
    logic        ins_wr;
    logic        st_set;
    bma_status_t st_val;
    logic        resp;
  } bma_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic size_bad;
    logic addr_bad;
    logic none_free;
    logic row_hit;
    logic split_more;
    logic fbad;
    logic merge_go;
    logic buddy_free;
    logic out_free;
  } bma_sts_t;

  // Rows of the free bitmap taken by one order of the tree.
  function automatic int fm_rows(input int m, input int j);
    int n;
    n = 1 << (m - j);
    return (n > FM_WORD_W) ? (n >> FM_BIT_W) : 1;
  endfunction

  // First row of an order; with k = m + 1 it gives the whole row count.
  function automatic int row_base(input int m, input int k);
    int s;
    s = 0;
    for (int j = 0; j < k; j++) s += fm_rows(m, j);
    return s;
  endfunction

endpackage

### design/bma_datapath.sv
// Datapath of the buddy allocator: bitmap and start-map memories, counters, result register.
module bma_datapath #(
  parameter int MAX_ORDER = bma_pkg::MAX_ORDER_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bma_pkg::bma_cmd_t            cmd,
  output bma_pkg::bma_sts_t            sts,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bma_pkg::SHIFT_W-1:0]  cfg_min_block_shift,
  input  logic                         in_op,
  input  logic [bma_pkg::BYTES_W-1:0]  in_request_bytes,
  input  logic [bma_pkg::ADDR_W-1:0]   in_block_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ok,
  output logic [1:0]                   out_status,
  output logic [bma_pkg::ADDR_W-1:0]   out_granted_address,
  output logic [bma_pkg::ORD_W-1:0]    out_granted_order,
  output logic [bma_pkg::BYTES_W-1:0]  out_bytes_in_use
);

  localparam int SHIFT_W = bma_pkg::SHIFT_W;
  localparam int ADDR_W  = bma_pkg::ADDR_W;
  localparam int BYTES_W = bma_pkg::BYTES_W;
  localparam int ORD_W   = bma_pkg::ORD_W;
  localparam int AM_W    = bma_pkg::AM_W;
  localparam int WW      = bma_pkg::FM_WORD_W;
  localparam int BW      = bma_pkg::FM_BIT_W;
  localparam int HEAP    = 1 << MAX_ORDER;
  localparam int OW      = $clog2(MAX_ORDER + 1);
  localparam int IW      = MAX_ORDER;
  localparam int XW      = MAX_ORDER + BW;
  localparam int FM_ROWS = bma_pkg::row_base(MAX_ORDER, MAX_ORDER + 1);
  localparam int RW      = (FM_ROWS > 1) ? $clog2(FM_ROWS) : 1;
  localparam int ROW_TOP = bma_pkg::row_base(MAX_ORDER, MAX_ORDER);
  localparam int CLR_LEN = (FM_ROWS > HEAP) ? FM_ROWS : HEAP;
  localparam int CLW     = $clog2(CLR_LEN);
  localparam int CNTW    = MAX_ORDER + 1;
  // The byte count can grow past the field width when the shift changes under held
  // blocks, so it is kept at full width and only the output is truncated.
  localparam int UW      = 64;
  localparam int CW      = ((UW > BYTES_W) ? UW : BYTES_W) + 1;

  logic [WW-1:0]   fm_mem [FM_ROWS];
  logic [AM_W-1:0] am_mem [HEAP];

  logic [SHIFT_W-1:0] shift_r;
  logic               op_r;
  logic [BYTES_W-1:0] size_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [OW-1:0]      need_r;
  logic [OW-1:0]      k_r;
  logic [IW-1:0]      idx_r;
  logic [RW-1:0]      row_r;
  logic [RW-1:0]      trow_r;
  logic [BW-1:0]      tbit_r;
  logic [CLW-1:0]     clr_r;
  logic [WW-1:0]      fm_rd_r;
  logic [AM_W-1:0]    am_rd_r;
  logic [CNTW-1:0]    cnt_r [MAX_ORDER+1];
  logic [UW-1:0]      used_r;
  logic [ADDR_W-1:0]  gaddr_r;
  logic [OW-1:0]      gord_r;
  bma_pkg::bma_status_t status_r;
  logic               out_valid_r;
  logic               out_ok_r;
  logic [1:0]         out_status_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [ORD_W-1:0]   out_ord_r;
  logic [BYTES_W-1:0] out_bytes_r;

  logic [RW-1:0]      rb_w [MAX_ORDER+1];
  logic [RW-1:0]      nr_w [MAX_ORDER+1];

  for (genvar g = 0; g <= MAX_ORDER; g++) begin : g_rows
    assign rb_w[g] = RW'(bma_pkg::row_base(MAX_ORDER, g));
    assign nr_w[g] = RW'(bma_pkg::fm_rows(MAX_ORDER, g));
  end

  // Size decode: bit length of size - 1 gives the rounded-up order.
  logic [BYTES_W-1:0] size_m1;
  logic [4:0]         blen;
  logic [OW-1:0]      need_c;
  logic [CW-1:0]      heap_c;
  logic               size_bad;

  always_comb begin
    size_m1 = size_r - BYTES_W'(1);
    blen    = '0;
    for (int i = 0; i < BYTES_W; i++) begin
      if (size_m1[i]) blen = 5'(i + 1);
    end
    need_c   = (blen > shift_r) ? OW'(blen - shift_r) : '0;
    heap_c   = CW'(1) << (6'(shift_r) + 6'(MAX_ORDER));
    size_bad = (size_r == '0) || (CW'(size_r) > heap_c);
  end

  // Free address decode.
  logic [ADDR_W-1:0] unit_c;
  logic [ADDR_W-1:0] ualign_c;
  logic              addr_bad;

  always_comb begin
    unit_c   = addr_r >> shift_r;
    ualign_c = (ADDR_W'(1) << shift_r) - ADDR_W'(1);
    addr_bad = ((addr_r & ualign_c) != '0) || ((unit_c >> MAX_ORDER) != '0);
  end

  // Lowest order at or above the need that still holds a free block.
  logic [OW-1:0] k_c;
  logic          k_any;

  always_comb begin
    k_c   = '0;
    k_any = 1'b0;
    for (int g = MAX_ORDER; g >= 0; g--) begin
      if ((cnt_r[g] != '0) && (OW'(g) >= need_r)) begin
        k_c   = OW'(g);
        k_any = 1'b1;
      end
    end
  end

  // Highest free bit of the row just read.
  logic [BW-1:0] hb;

  always_comb begin
    hb = '0;
    for (int i = 0; i < WW; i++) begin
      if (fm_rd_r[i]) hb = BW'(i);
    end
  end

  // Bitmap position of the node that the current step touches.
  logic [OW-1:0] sel_o;
  logic [IW-1:0] sel_i;
  logic [XW-1:0] sel_x;
  logic [RW-1:0] calc_row;
  logic [BW-1:0] calc_bit;

  always_comb begin
    if (cmd.split_rd) begin
      sel_o = k_r - OW'(1);
      sel_i = idx_r << 1;
    end else if (cmd.ins_rd || cmd.ins_wr) begin
      sel_o = k_r;
      sel_i = idx_r;
    end else begin
      sel_o = k_r;
      sel_i = idx_r ^ IW'(1);
    end
    sel_x    = XW'(sel_i);
    calc_row = rb_w[sel_o] + RW'(sel_x >> BW);
    calc_bit = sel_x[BW-1:0];
  end

  logic [XW-1:0] found_x;
  logic [IW-1:0] found_c;
  logic [IW-1:0] mark_unit;
  logic [OW-1:0] free_ord;
  logic [UW-1:0] free_amt;
  logic [UW-1:0] mark_amt;

  always_comb begin
    found_x   = (XW'(row_r - rb_w[k_r]) << BW) | XW'(hb);
    found_c   = found_x[IW-1:0];
    mark_unit = idx_r << need_r;
    free_ord  = OW'(am_rd_r - AM_W'(1));
    free_amt  = UW'(1) << (6'(shift_r) + 6'(free_ord));
    mark_amt  = UW'(1) << (6'(shift_r) + 6'(need_r));
  end

  // Memory port selection.
  logic          fm_we;
  logic [RW-1:0] fm_wa;
  logic [WW-1:0] fm_wd;
  logic [RW-1:0] fm_ra;
  logic          am_we;
  logic [IW-1:0] am_wa;
  logic [AM_W-1:0] am_wd;

  always_comb begin
    fm_we = 1'b0;
    fm_wa = row_r;
    fm_wd = '0;
    if (cmd.clr) begin
      fm_we = ({1'b0, clr_r} < (CLW+1)'(FM_ROWS));
      fm_wa = clr_r[RW-1:0];
      fm_wd = (fm_wa == RW'(ROW_TOP)) ? WW'(1) : '0;
    end else if (cmd.take) begin
      fm_we = 1'b1;
      fm_wa = row_r;
      fm_wd = fm_rd_r & ~(WW'(1) << hb);
    end else if (cmd.split_wr) begin
      fm_we = 1'b1;
      fm_wa = trow_r;
      fm_wd = fm_rd_r | (WW'(1) << tbit_r);
    end else if (cmd.merge_take) begin
      fm_we = 1'b1;
      fm_wa = calc_row;
      fm_wd = fm_rd_r & ~(WW'(1) << calc_bit);
    end else if (cmd.ins_wr) begin
      fm_we = 1'b1;
      fm_wa = calc_row;
      fm_wd = fm_rd_r | (WW'(1) << calc_bit);
    end
    fm_ra = (cmd.split_rd || cmd.merge_rd || cmd.ins_rd) ? calc_row : row_r;

    am_we = 1'b0;
    am_wa = unit_c[IW-1:0];
    am_wd = '0;
    if (cmd.clr) begin
      am_we = 1'b1;
      am_wa = clr_r[IW-1:0];
    end else if (cmd.fstart) begin
      am_we = 1'b1;
    end else if (cmd.mark) begin
      am_we = 1'b1;
      am_wa = mark_unit;
      am_wd = AM_W'(need_r) + AM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fm_we) fm_mem[fm_wa] <= fm_wd;
    fm_rd_r <= fm_mem[fm_ra];
  end

  always_ff @(posedge clk) begin
    if (am_we) am_mem[am_wa] <= am_wd;
    am_rd_r <= am_mem[unit_c[IW-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= SHIFT_W'(bma_pkg::SHIFT_RST);
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int g = 0; g <= MAX_ORDER; g++) begin
        cnt_r[g] <= (g == MAX_ORDER) ? CNTW'(1) : '0;
      end
    end else begin
      if (cfg_valid) begin
        shift_r <= (cfg_min_block_shift > SHIFT_W'(bma_pkg::SHIFT_MAX)) ?
                   SHIFT_W'(bma_pkg::SHIFT_MAX) : cfg_min_block_shift;
      end
      if (cmd.clr) clr_r <= clr_r + CLW'(1);
      if (cmd.mark) used_r <= used_r + mark_amt;
      if (cmd.fstart) used_r <= (used_r >= free_amt) ? used_r - free_amt : '0;
      for (int g = 0; g <= MAX_ORDER; g++) begin
        if (OW'(g) == k_r) begin
          if (cmd.take || cmd.merge_take) cnt_r[g] <= cnt_r[g] - CNTW'(1);
          else if (cmd.split_wr || cmd.ins_wr) cnt_r[g] <= cnt_r[g] + CNTW'(1);
        end
      end
      if (cmd.resp) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      size_r  <= in_request_bytes;
      addr_r  <= in_block_address;
      gaddr_r <= '0;
      gord_r  <= '0;
    end
    if (cmd.decode) need_r <= need_c;
    if (cmd.st_set) status_r <= cmd.st_val;
    if (cmd.pick) begin
      k_r   <= k_c;
      row_r <= rb_w[k_c] + nr_w[k_c] - RW'(1);
    end
    if (cmd.scan_next) row_r <= row_r - RW'(1);
    if (cmd.take) idx_r <= found_c;
    if (cmd.split_rd) begin
      trow_r <= calc_row;
      tbit_r <= calc_bit;
      k_r    <= k_r - OW'(1);
      idx_r  <= (idx_r << 1) | IW'(1);
    end
    if (cmd.mark) begin
      gaddr_r <= ADDR_W'(mark_unit) << shift_r;
      gord_r  <= need_r;
    end
    if (cmd.fstart) begin
      k_r    <= free_ord;
      gord_r <= free_ord;
      idx_r  <= unit_c[IW-1:0] >> free_ord;
    end
    if (cmd.merge_take) begin
      k_r   <= k_r + OW'(1);
      idx_r <= idx_r >> 1;
    end
    if (cmd.resp) begin
      out_ok_r     <= (status_r == bma_pkg::ST_OK);
      out_status_r <= status_r;
      out_addr_r   <= gaddr_r;
      out_ord_r    <= ORD_W'(gord_r);
      out_bytes_r  <= BYTES_W'(used_r);
    end
  end

  always_comb begin
    sts.clr_done   = (clr_r == CLW'(CLR_LEN - 1));
    sts.is_free    = op_r;
    sts.size_bad   = size_bad;
    sts.addr_bad   = addr_bad;
    sts.none_free  = !k_any;
    sts.row_hit    = (fm_rd_r != '0);
    sts.split_more = (k_r > need_r);
    sts.fbad       = (am_rd_r == '0) || (am_rd_r > AM_W'(MAX_ORDER + 1));
    sts.merge_go   = (k_r < OW'(MAX_ORDER));
    sts.buddy_free = fm_rd_r[calc_bit];
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_ok              = out_ok_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;
  assign out_granted_order   = out_ord_r;
  assign out_bytes_in_use    = out_bytes_r;

endmodule

### design/bma_ctrl.sv
// Controller state machine of the buddy allocator.
module bma_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bma_pkg::bma_sts_t sts,
  output bma_pkg::bma_cmd_t cmd
);

  bma_pkg::bma_state_t state_r;
  bma_pkg::bma_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bma_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bma_pkg::S_CLEAR: begin
        if (sts.clr_done) state_nxt = bma_pkg::S_IDLE;
      end
      bma_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bma_pkg::S_DECODE;
      end
      bma_pkg::S_DECODE: begin
        if (sts.is_free) begin
          state_nxt = sts.addr_bad ? bma_pkg::S_RESP : bma_pkg::S_FCHK;
        end else begin
          state_nxt = sts.size_bad ? bma_pkg::S_RESP : bma_pkg::S_PICK;
        end
      end
      bma_pkg::S_PICK: begin
        state_nxt = sts.none_free ? bma_pkg::S_RESP : bma_pkg::S_SCAN_RD;
      end
      bma_pkg::S_SCAN_RD: state_nxt = bma_pkg::S_SCAN_CHK;
      bma_pkg::S_SCAN_CHK: begin
        if (!sts.row_hit) state_nxt = bma_pkg::S_SCAN_RD;
        else if (sts.split_more) state_nxt = bma_pkg::S_SPLIT_RD;
        else state_nxt = bma_pkg::S_MARK;
      end
      bma_pkg::S_SPLIT_RD: state_nxt = bma_pkg::S_SPLIT_WR;
      bma_pkg::S_SPLIT_WR: begin
        state_nxt = sts.split_more ? bma_pkg::S_SPLIT_RD : bma_pkg::S_MARK;
      end
      bma_pkg::S_MARK: state_nxt = bma_pkg::S_RESP;
      bma_pkg::S_FCHK: begin
        state_nxt = sts.fbad ? bma_pkg::S_RESP : bma_pkg::S_MERGE_RD;
      end
      bma_pkg::S_MERGE_RD: begin
        state_nxt = sts.merge_go ? bma_pkg::S_MERGE_CHK : bma_pkg::S_INS_RD;
      end
      bma_pkg::S_MERGE_CHK: begin
        state_nxt = sts.buddy_free ? bma_pkg::S_MERGE_RD : bma_pkg::S_INS_RD;
      end
      bma_pkg::S_INS_RD: state_nxt = bma_pkg::S_INS_WR;
      bma_pkg::S_INS_WR: state_nxt = bma_pkg::S_RESP;
      bma_pkg::S_RESP: begin
        if (sts.out_free) state_nxt = bma_pkg::S_IDLE;
      end
      default: state_nxt = bma_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.st_val = bma_pkg::ST_OK;
    in_stall   = (state_r != bma_pkg::S_IDLE);
    case (state_r)
      bma_pkg::S_CLEAR: cmd.clr = 1'b1;
      bma_pkg::S_IDLE: cmd.load = in_valid;
      bma_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.is_free && sts.addr_bad) begin
          cmd.st_set = 1'b1;
          cmd.st_val = bma_pkg::ST_BAD_ADDR;
        end else if (!sts.is_free && sts.size_bad) begin
          cmd.st_set = 1'b1;
          cmd.st_val = bma_pkg::ST_BAD_SIZE;
        end
      end
      bma_pkg::S_PICK: begin
        if (sts.none_free) begin
          cmd.st_set = 1'b1;
          cmd.st_val = bma_pkg::ST_NO_FREE;
        end else begin
          cmd.pick = 1'b1;
        end
      end
      bma_pkg::S_SCAN_CHK: begin
        cmd.take      = sts.row_hit;
        cmd.scan_next = !sts.row_hit;
      end
      bma_pkg::S_SPLIT_RD: cmd.split_rd = 1'b1;
      bma_pkg::S_SPLIT_WR: cmd.split_wr = 1'b1;
      bma_pkg::S_MARK: begin
        cmd.mark   = 1'b1;
        cmd.st_set = 1'b1;
      end
      bma_pkg::S_FCHK: begin
        if (sts.fbad) begin
          cmd.st_set = 1'b1;
          cmd.st_val = bma_pkg::ST_BAD_ADDR;
        end else begin
          cmd.fstart = 1'b1;
        end
      end
      bma_pkg::S_MERGE_RD: cmd.merge_rd = sts.merge_go;
      bma_pkg::S_MERGE_CHK: cmd.merge_take = sts.buddy_free;
      bma_pkg::S_INS_RD: cmd.ins_rd = 1'b1;
      bma_pkg::S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        cmd.st_set = 1'b1;
      end
      bma_pkg::S_RESP: cmd.resp = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### design/buddy_memory_allocator.sv
// One item at a time: the bitmap memory takes one read-modify-write per tree level,
// and scanning an order reads 32 free bits a row, so a new item is taken only after
// the last one has been answered. Reset is synchronous; afterwards a clearing pass
// initialises both memories, during which no item is taken.
module buddy_memory_allocator #(
  parameter int MAX_ORDER = bma_pkg::MAX_ORDER_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bma_pkg::SHIFT_W-1:0]  cfg_min_block_shift,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [bma_pkg::BYTES_W-1:0]  in_request_bytes,
  input  logic [bma_pkg::ADDR_W-1:0]   in_block_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ok,
  output logic [1:0]                   out_status,
  output logic [bma_pkg::ADDR_W-1:0]   out_granted_address,
  output logic [bma_pkg::ORD_W-1:0]    out_granted_order,
  output logic [bma_pkg::BYTES_W-1:0]  out_bytes_in_use
);

  bma_pkg::bma_cmd_t cmd;
  bma_pkg::bma_sts_t sts;

  bma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bma_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_min_block_shift (cfg_min_block_shift),
    .in_op               (in_op),
    .in_request_bytes    (in_request_bytes),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ok              (out_ok),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_granted_order   (out_granted_order),
    .out_bytes_in_use    (out_bytes_in_use)
  );

endmodule

### design/bma_checker.sv
// Port-level checker of the buddy allocator and its bind.
`include "buddy_memory_allocator_defines.svh"

module bma_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_ok,
  input logic [1:0]                   out_status,
  input logic [bma_pkg::ADDR_W-1:0]   out_granted_address,
  input logic [bma_pkg::ORD_W-1:0]    out_granted_order,
  input logic [bma_pkg::BYTES_W-1:0]  out_bytes_in_use
);

  // Only one item is in flight, so the input closes right after an item is taken.
  `BMA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall, "item taken while busy")

  `BMA_ASSERT_SAME(a_ok_matches, clk, rst_n, out_valid, out_ok == (out_status == bma_pkg::ST_OK), "ok flag disagrees with status")

  `BMA_ASSERT_SAME(a_fail_zero, clk, rst_n, out_valid && !out_ok, (out_granted_address == '0) && (out_granted_order == '0), "failed item carries a block")

  `BMA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_bytes_in_use) && $stable(out_status), "stalled result changed")

endmodule

bind buddy_memory_allocator bma_checker u_bma_checker (.*);
